FILE: hw/rtl/ldac_pkg.sv
// Shared widths, register indexes and divider constants for the lossy DPCM audio codec.
`default_nettype none

package ldac_pkg;

  // Width of a coded sample; encoded inputs are cut to this many bits, sign extended.
  localparam int SAMPLE_WIDTH = 16;

  // Item fields.
  localparam int VALUE_W  = 17;
  localparam int RESULT_W = 32;
  localparam int STEP_W   = 16;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // Residuals and products are carried in this many bits before the final wrap.
  localparam int WIDE_W = 34;

  // The divider retires this many quotient bits each cycle.
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES         = WIDE_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_PRED_SEL   = 1'b0,
    CFG_QUANT_STEP = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lossy_dpcm_audio_codec.sv
// Top level of the lossy DPCM audio codec: predictor, shared serial divider and sequencer.
//
//  Channel | Ports                          | Word contents (lowest bit first)
//  --------+--------------------------------+-------------------------------------------
//  input   | in_tvalid in_tready in_tdata   | tdata: value[16:0], zero pad to 24 bits
//          | in_tuser                       | tuser: command, start_req
//  result  | out_tvalid out_tready out_tdata| tdata: result_value[31:0]
//  config  | cfg_we cfg_index cfg_wdata     | 0: predictor_select, 1: quant_step
//
// Each word passes the predict, difference and done states; an encode word at stream
// position two or later also passes the divide and fix states, where the serial divider
// retires two quotient bits per cycle over a 34-bit residual magnitude.
// Reset is synchronous and active low; it clears the history, the stream position and the
// configuration. A finished result sits in the output register while the next word is
// accepted; a word whose result is ready waits only if that register is still full.
`default_nettype none

module lossy_dpcm_audio_codec (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ldac_pkg::IN_TDATA_W-1:0] in_tdata,   // value[16:0], pad
  input  wire logic [ldac_pkg::IN_TUSER_W-1:0] in_tuser,   // command, start_req
  // Result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [ldac_pkg::OUT_TDATA_W-1:0]    out_tdata,   // result_value[31:0]
  // Configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [0:0]                     cfg_index,
  input  wire logic [ldac_pkg::STEP_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIFF,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  localparam int VW = ldac_pkg::VALUE_W;
  localparam int RW = ldac_pkg::RESULT_W;
  localparam int WW = ldac_pkg::WIDE_W;
  localparam int SW = ldac_pkg::STEP_W;
  localparam int SHIFT = (ldac_pkg::SAMPLE_WIDTH < VW) ? VW - ldac_pkg::SAMPLE_WIDTH : 0;

  state_t                          state_r;
  logic                            pred_sel_r;
  logic [SW-1:0]                   quant_step_r;
  logic signed [RW-1:0]            older_r;
  logic signed [RW-1:0]            newer_r;
  logic [1:0]                      pos_r;

  // Item being worked on.
  logic                            cmd_r;
  logic [1:0]                      item_pos_r;
  logic signed [VW-1:0]            value_r;
  logic signed [RW:0]              pred_r;
  logic signed [WW-1:0]            prod_r;
  logic [RW-1:0]                   res_r;

  // Divider registers.
  logic                            neg_r;
  logic [SW-1:0]                   rem_r;
  logic [WW-1:0]                   quo_r;
  logic [ldac_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [SW-1:0]                   rem_nxt;
  logic [WW-1:0]                   quo_nxt;

  logic                            out_valid_r;
  logic [RW-1:0]                   out_data_r;

  logic [SW-1:0]                   step_eff;
  logic signed [VW-1:0]            value_shl;
  logic signed [VW-1:0]            value_enc;
  logic signed [RW:0]              hist_sum;
  logic signed [RW:0]              hist_avg;
  logic signed [RW:0]              pred_sel;
  logic signed [WW-1:0]            enc_diff;
  logic signed [WW-1:0]            dec_sum;
  logic [WW-1:0]                   quo_signed;
  logic [1:0]                      in_pos;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ldac_pkg::OUT_TDATA_W'(out_data_r);

  // A zero step behaves as a step of one.
  assign step_eff = (quant_step_r == '0) ? SW'(1) : quant_step_r;

  // Encoded samples keep only the low sample-width bits, sign extended.
  assign value_shl = value_r <<< SHIFT;
  assign value_enc = value_shl >>> SHIFT;

  // From position two: truncated average of the last two values, or the value two back.
  assign hist_sum = {older_r[RW-1], older_r} + {newer_r[RW-1], newer_r};
  assign hist_avg = (hist_sum + $signed({{RW{1'b0}}, hist_sum[RW]})) >>> 1;

  always_comb begin
    if (item_pos_r[1]) begin
      pred_sel = pred_sel_r ? hist_avg : {older_r[RW-1], older_r};
    end else if (item_pos_r == 2'd1 && pred_sel_r) begin
      pred_sel = {newer_r[RW-1], newer_r};
    end else begin
      pred_sel = '0;
    end
  end

  assign enc_diff   = WW'(value_enc) - WW'(pred_r);
  assign dec_sum    = prod_r + WW'(pred_r);
  assign quo_signed = neg_r ? (~quo_r + WW'(1)) : quo_r;
  assign in_pos     = in_tuser[1] ? 2'd0 : pos_r;

  // Restoring division step, two quotient bits per cycle.
  always_comb begin
    logic [SW:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < ldac_pkg::DIV_BITS_PER_CYCLE; k++) begin
      trial   = {rem_nxt, quo_nxt[WW-1]};
      quo_nxt = {quo_nxt[WW-2:0], 1'b0};
      if (trial >= {1'b0, step_eff}) begin
        rem_nxt    = SW'(trial - {1'b0, step_eff});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[SW-1:0];
      end
    end
  end

  // Sequencer, history, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pred_sel_r   <= 1'b0;
      quant_step_r <= SW'(1);
      older_r      <= '0;
      newer_r      <= '0;
      pos_r        <= 2'd0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (ldac_pkg::cfg_idx_t'(cfg_index))
          ldac_pkg::CFG_PRED_SEL:   pred_sel_r   <= cfg_wdata[0];
          ldac_pkg::CFG_QUANT_STEP: quant_step_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r      <= in_tuser[0];
            item_pos_r <= in_pos;
            value_r    <= $signed(in_tdata[VW-1:0]);
            state_r    <= S_PRED;
          end
        end
        S_PRED: begin
          pred_r <= pred_sel;
          prod_r <= item_pos_r[1] ? WW'(value_r * $signed({1'b0, step_eff}))
                                  : WW'(value_r);
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          if (cmd_r) begin
            res_r   <= dec_sum[RW-1:0];
            state_r <= S_DONE;
          end else if (!item_pos_r[1]) begin
            res_r   <= enc_diff[RW-1:0];
            state_r <= S_DONE;
          end else begin
            neg_r   <= enc_diff[WW-1];
            quo_r   <= enc_diff[WW-1] ? WW'(-enc_diff) : enc_diff;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ldac_pkg::DIV_CNT_W'(ldac_pkg::DIV_CYCLES - 1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          res_r   <= quo_signed[RW-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the output register is free, then advance history.
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            older_r     <= newer_r;
            newer_r     <= cmd_r ? $signed(res_r) : RW'(value_enc);
            pos_r       <= item_pos_r[1] ? item_pos_r : item_pos_r + 2'd1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ldac_checker.sv
// Port-level checker for the lossy DPCM audio codec, bound to the top level.
`default_nettype none

module ldac_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ldac_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // One word is worked on at a time: an accepted word closes the input side.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready again in the cycle after an accept");

  // A new result only appears while a word is in work.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result word without a word in work");

  // A stalled result word holds its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed or dropped");

endmodule

bind lossy_dpcm_audio_codec ldac_checker u_ldac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: bench/lossy_dpcm_audio_codec_tb.sv
// Self-checking bench for the lossy DPCM audio codec: stream driver, result monitor, predictor.
module lossy_dpcm_audio_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 11;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 30;

  localparam int VW  = ldac_pkg::VALUE_W;
  localparam int RW  = ldac_pkg::RESULT_W;
  localparam int STW = ldac_pkg::STEP_W;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } codec_cmd_t;

  typedef enum logic {
    PRED_SAME_CHANNEL = 1'b0,
    PRED_AVERAGE      = 1'b1
  } pred_mode_t;

  typedef struct packed {
    codec_cmd_t          command;
    logic                start_req;
    logic [VW-1:0]       value;
  } codec_word_t;

  // Block ports.
  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [ldac_pkg::IN_TDATA_W-1:0]  in_tdata = '0;    // value[16:0], zero pad
  logic [ldac_pkg::IN_TUSER_W-1:0]  in_tuser = '0;    // command, start_req
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ldac_pkg::OUT_TDATA_W-1:0] out_tdata;        // result_value[31:0]
  logic                             cfg_we = 1'b0;
  logic [0:0]                       cfg_index = '0;
  logic [STW-1:0]                   cfg_wdata = '0;

  // Words waiting to be sent and results waiting to arrive.
  codec_word_t         pending_words[$];
  logic [RW-1:0]       results_due[$];

  // Bench copy of the configuration and of the coder history.
  pred_mode_t          pred_mode = PRED_SAME_CHANNEL;
  logic [STW-1:0]      step_copy = 16'd1;
  logic [RW-1:0]       hist_older = '0;
  logic [RW-1:0]       hist_newer = '0;
  int                  stream_pos = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int encode_words = 0;
  int decode_words = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  lossy_dpcm_audio_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Codes one word against the bench history and advances that history.
  function automatic logic [RW-1:0] code_word(codec_word_t w);
    longint v, older, newer, q, pred, full;
    logic [RW-1:0] sample, res;
    v     = longint'($signed(w.value));
    older = longint'($signed(hist_older));
    newer = longint'($signed(hist_newer));
    q     = (step_copy == '0) ? 64'sd1 : longint'(step_copy);
    if (w.start_req) begin
      stream_pos = 0;
    end
    if (stream_pos >= 2) begin
      pred = (pred_mode == PRED_AVERAGE) ? (older + newer) / 2 : older;
    end else if (stream_pos == 1 && pred_mode == PRED_AVERAGE) begin
      pred = newer;
    end else begin
      pred = 0;
    end
    if (w.command == CMD_ENCODE) begin
      // Only the low sample bits of an encoded value count.
      if (ldac_pkg::SAMPLE_WIDTH < VW) begin
        v = (v <<< (64 - ldac_pkg::SAMPLE_WIDTH)) >>> (64 - ldac_pkg::SAMPLE_WIDTH);
      end
      sample = v[RW-1:0];
      full   = (stream_pos >= 2) ? (v - pred) / q : v - pred;
      res    = full[RW-1:0];
    end else begin
      full   = (stream_pos >= 2) ? v * q + pred : v + pred;
      sample = full[RW-1:0];
      res    = sample;
    end
    hist_older = hist_newer;
    hist_newer = sample;
    if (stream_pos < 2) begin
      stream_pos++;
    end
    return res;
  endfunction

  // Driver: presents queued words and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        results_due.push_back(code_word(codec_word_t'({in_tuser[0], in_tuser[1],
                                                      in_tdata[VW-1:0]})));
        if (in_tuser[0] == CMD_DECODE) begin
          decode_words++;
        end else begin
          encode_words++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          codec_word_t w;
          w = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(ldac_pkg::IN_TDATA_W - VW){1'b0}}, w.value};
          in_tuser  <= {w.start_req, w.command};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: throttles the result side and checks every accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result_value: no result expected, got %0d",
                 $signed(out_tdata[RW-1:0]));
          error_count++;
        end else begin
          logic [RW-1:0] want;
          want = results_due.pop_front();
          if (out_tdata[RW-1:0] !== want) begin
            $error("result_value: expected %0d, got %0d", $signed(want),
                   $signed(out_tdata[RW-1:0]));
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_word(input codec_cmd_t cmd, input logic start, input logic [16:0] val);
    codec_word_t w;
    w.command   = cmd;
    w.start_req = start;
    w.value     = val;
    pending_words.push_back(w);
  endtask

  // Waits until every queued word was sent and every result has come back.
  // Checked between edges, once the driver and monitor have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (!(pending_words.size() == 0 && !in_tvalid && results_due.size() == 0)) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input ldac_pkg::cfg_idx_t idx, input logic [STW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ldac_pkg::CFG_PRED_SEL) begin
      pred_mode = pred_mode_t'(data[0]);
    end else begin
      step_copy = data;
    end
  endtask

  task automatic set_config(input pred_mode_t mode, input logic [STW-1:0] step);
    wait_drained();
    write_reg(ldac_pkg::CFG_PRED_SEL, {{(STW - 1){1'b0}}, mode});
    write_reg(ldac_pkg::CFG_QUANT_STEP, step);
  endtask

  // Field extremes show up often; the rest is uniform over all 17 bits.
  function automatic logic [16:0] pick_value();
    case ($urandom_range(9))
      0:       return 17'h0FFFF;
      1:       return 17'h10000;
      2:       return 17'h00000;
      3:       return 17'h1FFFF;
      4:       return 17'h07FFF;
      5:       return 17'h18000;
      default: return 17'($urandom_range(0, 17'h1FFFF));
    endcase
  endfunction

  // Mostly well-formed streams that open with a restart, some mixed or broken ones.
  task automatic queue_streams(input int count);
    int n, len, k;
    logic mixed, opens;
    codec_cmd_t cmd;
    n = 0;
    while (n < count) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      cmd   = codec_cmd_t'($urandom_range(1));
      mixed = ($urandom_range(5) == 0);
      opens = ($urandom_range(9) != 0);
      for (k = 0; k < len && n < count; k++) begin
        push_word(mixed ? codec_cmd_t'($urandom_range(1)) : cmd,
                  (k == 0 && opens) || ($urandom_range(29) == 0), pick_value());
        n++;
      end
    end
  endtask

  task automatic run_phase(input pred_mode_t mode, input logic [STW-1:0] step,
                           input int count, input int s_pct, input int r_pct,
                           input logic pause_midway);
    set_config(mode, step);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (pause_midway) begin
      // Sender holds off until everything in flight has come back.
      queue_streams(count / 2);
      wait_drained();
      queue_streams(count - count / 2);
    end else begin
      queue_streams(count);
    end
  endtask

  // Stimulus sequence.
  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 49;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: field extremes, both commands, sample width cut.
    push_word(CMD_ENCODE, 1'b1, 17'h0FFFF);
    push_word(CMD_ENCODE, 1'b0, 17'h10000);
    push_word(CMD_ENCODE, 1'b0, 17'h07FFF);
    push_word(CMD_ENCODE, 1'b0, 17'h18000);
    push_word(CMD_DECODE, 1'b0, 17'h0FFFF);
    push_word(CMD_DECODE, 1'b0, 17'h10000);
    push_word(CMD_DECODE, 1'b0, 17'h00000);

    // Average predictor with a step of three: first-position offset, truncation
    // toward zero of negative residuals and of an odd negative sum.
    set_config(PRED_AVERAGE, 16'd3);
    push_word(CMD_ENCODE, 1'b1, 17'd100);
    push_word(CMD_ENCODE, 1'b0, 17'd7);
    push_word(CMD_ENCODE, 1'b0, -17'sd50);
    push_word(CMD_ENCODE, 1'b0, 17'd1);
    push_word(CMD_DECODE, 1'b1, 17'h10000);
    push_word(CMD_DECODE, 1'b0, 17'h0FFFF);
    push_word(CMD_DECODE, 1'b0, 17'h1FFFF);
    push_word(CMD_DECODE, 1'b0, 17'd5);

    // A zero step acts as one; a restart in the middle of a stream; mixed commands.
    set_config(PRED_SAME_CHANNEL, 16'd0);
    push_word(CMD_ENCODE, 1'b1, 17'd10);
    push_word(CMD_ENCODE, 1'b0, 17'd20);
    push_word(CMD_ENCODE, 1'b0, 17'd25);
    push_word(CMD_DECODE, 1'b0, 17'd3);
    push_word(CMD_DECODE, 1'b1, 17'd4);
    push_word(CMD_ENCODE, 1'b0, 17'd9);

    // Random streams over several settings and three idle profiles.
    run_phase(PRED_SAME_CHANNEL, 16'd1, 80, 23, 49, 1'b0);
    run_phase(PRED_AVERAGE, 16'd1, 80, 23, 49, 1'b0);
    run_phase(PRED_SAME_CHANNEL, 16'hFFFF, 80, 23, 49, 1'b0);
    run_phase(PRED_AVERAGE, 16'hFFFF, 80, 49, 23, 1'b0);
    run_phase(PRED_SAME_CHANNEL, 16'($urandom_range(2, 65534)), 80, 49, 23, 1'b0);
    run_phase(PRED_AVERAGE, 16'($urandom_range(2, 65534)), 80, 49, 23, 1'b1);
    run_phase(PRED_AVERAGE, 16'($urandom_range(2, 16)), 60, 0, 0, 1'b0);
    run_phase(PRED_SAME_CHANNEL, 16'($urandom_range(2, 16)), 100, 0, 0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d encode and %0d decode words, %0d results checked,",
             encode_words, decode_words, results_seen);
    $display("both predictors, steps from zero to full scale, three idle profiles.");
    if (error_count == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
